// ===== src/bmh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmh_pkg
// Shared constants and types for the binary min-heap priority queue.
// ----------------------------------------------------------------------------
package bmh_pkg;

    localparam int DEFAULT_CAPACITY = 256;
    localparam int KEY_W            = 32;
    localparam int VAL_W            = 32;
    localparam int LIMIT_W          = 9;
    localparam int FIDX_W           = 8;
    localparam int CNT_W            = 9;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_EXTRACT  = 2'd1,
        OP_DECREASE = 2'd2,
        OP_PEEK     = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_FULL       = 3'd1,
        ST_EMPTY      = 3'd2,
        ST_NOTFOUND   = 3'd3,
        ST_NOTSMALLER = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0]             op;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [2:0]              status;
        logic signed [KEY_W-1:0] out_key;
        logic signed [VAL_W-1:0] out_value;
        logic [FIDX_W-1:0]       final_index;
        logic [CNT_W-1:0]        entry_count;
    } t_rsp;

endpackage
`default_nettype wire

// ===== src/bmh_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmh_req_if / bmh_rsp_if
// Valid/ready channels carrying heap requests and responses.
// ----------------------------------------------------------------------------
interface bmh_req_if;
    import bmh_pkg::*;
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bmh_rsp_if;
    import bmh_pkg::*;
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== src/bmh_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmh_store
// Heap entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bmh_store #(
    parameter int CAPACITY = bmh_pkg::DEFAULT_CAPACITY,
    parameter int AW       = $clog2(CAPACITY)
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_we,
    input  wire logic [AW-1:0]                   i_waddr,
    input  wire logic [bmh_pkg::KEY_W+bmh_pkg::VAL_W-1:0] i_wdata,
    input  wire logic [AW-1:0]                   i_raddr,
    output logic [bmh_pkg::KEY_W+bmh_pkg::VAL_W-1:0]      o_rdata
);
    import bmh_pkg::*;

    logic [KEY_W+VAL_W-1:0] r_mem [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== src/binary_min_heap_priority_queue_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binary_min_heap_priority_queue_core
// Min-heap of (key, value) pairs with insert, extract, decrease and peek.
// ----------------------------------------------------------------------------
// One request at a time: ready is low from the accepted transfer until the
// response has been taken. Entries live in a memory with one registered read
// port and a sequencer walks the heap with one signed key comparator, moving
// a hole instead of swapping. Insert climbs from the new last slot;
// extract moves the old last entry down from the root when entries remain;
// decrease key first reads every entry for the value, then climbs from the
// last match.
module binary_min_heap_priority_queue_core #(
    parameter int CAPACITY = bmh_pkg::DEFAULT_CAPACITY
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [bmh_pkg::LIMIT_W-1:0] cfg_wdata,
    bmh_req_if.sink                          req,
    bmh_rsp_if.source                        rsp
);
    import bmh_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int PW = AW + 1;   // wide enough to hold CAPACITY and 2*pos+2 for a pos with a child

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_ROOT, S_SCAN, S_DEC_CHK, S_UP, S_UP_CMP,
        S_DN_LAST, S_DN, S_DN_L, S_DN_R, S_DN_MOVE, S_DONE
    } t_state;

    t_state r_state;
    logic [LIMIT_W-1:0] r_limit;
    logic [PW-1:0] r_count;
    t_req r_req;
    logic [PW-1:0] r_pos, r_idx, r_least, r_found;
    logic r_hit;
    logic [KEY_W+VAL_W-1:0] r_cur, r_best;   // moving entry, best candidate
    logic r_has_best;
    t_rsp r_rsp;
    logic r_rsp_valid;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [KEY_W+VAL_W-1:0] wdata, rdata;

    bmh_store #(.CAPACITY(CAPACITY), .AW(AW)) u_store (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    logic signed [KEY_W-1:0] rd_key, cur_key, best_key, cmp_a, cmp_b;
    logic less;
    logic [PW-1:0] limit_eff, parent, lchild, rchild;
    assign rd_key   = rdata[KEY_W+VAL_W-1:VAL_W];
    assign cur_key  = r_cur[KEY_W+VAL_W-1:VAL_W];
    assign best_key = r_best[KEY_W+VAL_W-1:VAL_W];
    assign less     = cmp_a < cmp_b;   // the shared comparator
    assign parent   = (r_pos - PW'(1)) >> 1;
    assign lchild   = {r_pos[PW-2:0], 1'b1};
    assign rchild   = {r_pos[PW-2:0], 1'b0} + PW'(2);
    assign limit_eff = (32'(r_limit) > CAPACITY) ? PW'(CAPACITY) : PW'(r_limit);

    always_comb begin
        cmp_a = rd_key;
        cmp_b = cur_key;
        unique case (r_state)
            S_DEC_CHK: begin cmp_a = r_req.key; cmp_b = cur_key;  end
            S_UP_CMP:  begin cmp_a = cur_key;   cmp_b = rd_key;   end
            S_DN_R:    begin cmp_a = rd_key;    cmp_b = best_key; end
            default:   ;
        endcase
    end

    // memory port steering; the root is read in DISPATCH
    always_comb begin
        we = 1'b0;
        waddr = r_pos[AW-1:0];
        wdata = r_cur;
        raddr = '0;
        unique case (r_state)
            S_SCAN:   raddr = AW'(r_idx + PW'(1));
            S_ROOT:   raddr = AW'(r_count - PW'(1));
            S_UP: begin
                if (r_pos == '0) we = 1'b1;
                else raddr = parent[AW-1:0];
            end
            S_UP_CMP: begin
                // parent moves down into the hole, or the entry settles
                we = 1'b1;
                if (less) wdata = rdata;
            end
            S_DN: begin
                if (lchild >= r_count) we = 1'b1;
                else raddr = lchild[AW-1:0];
            end
            S_DN_L:   raddr = rchild[AW-1:0];
            S_DN_MOVE: begin
                we = 1'b1;
                if (r_has_best) wdata = r_best;
            end
            default:  ;
        endcase
    end

    assign req.ready = (r_state == S_IDLE) && !r_rsp_valid;
    assign rsp.valid = r_rsp_valid;
    assign rsp.payload = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_limit <= LIMIT_RESET;
            r_count <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (cfg_we) r_limit <= cfg_wdata;
            if (rsp.valid && rsp.ready) r_rsp_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (req.valid && req.ready) begin
                        r_req <= req.payload;
                        r_rsp <= '0;
                        r_state <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    r_state <= S_DONE;
                    unique case (t_op'(r_req.op))
                        OP_INSERT: begin
                            if (r_count >= limit_eff) begin
                                r_rsp.status <= ST_FULL;
                            end else begin
                                r_cur <= {r_req.key, r_req.value};
                                r_pos <= r_count;
                                r_count <= r_count + PW'(1);
                                r_state <= S_UP;
                            end
                        end
                        OP_EXTRACT, OP_PEEK: begin
                            if (r_count == '0) r_rsp.status <= ST_EMPTY;
                            else r_state <= S_ROOT;
                        end
                        OP_DECREASE: begin
                            r_idx <= '0;
                            r_hit <= 1'b0;
                            if (r_count == '0) r_rsp.status <= ST_NOTFOUND;
                            else r_state <= S_SCAN;
                        end
                    endcase
                end
                S_ROOT: begin
                    r_rsp.out_key <= rd_key;
                    r_rsp.out_value <= rdata[VAL_W-1:0];
                    if (r_req.op == OP_PEEK) begin
                        r_state <= S_DONE;
                    end else begin
                        r_count <= r_count - PW'(1);
                        r_state <= (r_count == PW'(1)) ? S_DONE : S_DN_LAST;
                    end
                end
                S_DN_LAST: begin
                    // old last entry starts its way down from the root
                    r_cur <= rdata;
                    r_pos <= '0;
                    r_state <= S_DN;
                end
                S_DN: begin
                    r_state <= (lchild >= r_count) ? S_DONE : S_DN_L;
                end
                S_DN_L: begin
                    r_least <= lchild;
                    r_has_best <= less;
                    r_best <= less ? rdata : r_cur;
                    r_state <= (rchild < r_count) ? S_DN_R : S_DN_MOVE;
                end
                S_DN_R: begin
                    if (less) begin
                        r_best <= rdata;
                        r_has_best <= 1'b1;
                        r_least <= rchild;
                    end
                    r_state <= S_DN_MOVE;
                end
                S_DN_MOVE: begin
                    if (r_has_best) begin
                        r_pos <= r_least;
                        r_state <= S_DN;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_SCAN: begin
                    // keep the last match
                    if (rdata[VAL_W-1:0] == r_req.value) begin
                        r_hit <= 1'b1;
                        r_found <= r_idx;
                        r_cur <= rdata;
                    end
                    if (r_idx + PW'(1) == r_count) r_state <= S_DEC_CHK;
                    else r_idx <= r_idx + PW'(1);
                end
                S_DEC_CHK: begin
                    if (!r_hit) begin
                        r_rsp.status <= ST_NOTFOUND;
                        r_state <= S_DONE;
                    end else if (!less) begin
                        r_rsp.status <= ST_NOTSMALLER;
                        r_state <= S_DONE;
                    end else begin
                        r_cur <= {r_req.key, r_cur[VAL_W-1:0]};
                        r_pos <= r_found;
                        r_state <= S_UP;
                    end
                end
                S_UP: r_state <= (r_pos == '0) ? S_DONE : S_UP_CMP;
                S_UP_CMP: begin
                    if (less) begin
                        r_pos <= parent;
                        r_state <= S_UP;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_rsp.entry_count <= CNT_W'(r_count);
                    if (r_req.op == OP_DECREASE && r_rsp.status == ST_OK) begin
                        r_rsp.final_index <= FIDX_W'(r_pos);
                    end
                    r_rsp_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
